// File: rtl/core/lnp_pkg.sv
// ----------------------------------------------------------------------------
// lnp_pkg
// Shared types, constants and helpers of the lexicographic permutation block.
// ----------------------------------------------------------------------------
package lnp_pkg;

    localparam int MAX_LEN = 16;
    localparam int DATA_W  = 16;
    localparam int LEN_W   = 5;
    localparam int POS_W   = 4;
    localparam int KIND_W  = 2;
    localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int EFF_W   = (LEN_W > CNT_W) ? LEN_W : CNT_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_EMIT  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_RSVD  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_SCAN,
        ST_LD_TAIL,
        ST_PRE,
        ST_EMIT,
        ST_FIND,
        ST_SWAP,
        ST_REV_RD,
        ST_REV_WLO,
        ST_REV_WHI
    } state_t;

    typedef struct packed {
        logic                     we;
        logic [IDX_W-1:0]         addr;
        logic signed [DATA_W-1:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] element;
        logic [POS_W-1:0]         position;
        logic                     last_of_run;
        logic                     final_arrangement;
    } res_t;

    // configured length with zero taken as one and saturated to the store depth
    function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [EFF_W-1:0] l;
        l = EFF_W'(len);
        if (l == '0) l = EFF_W'(1);
        if (l > EFF_W'(MAX_LEN)) l = EFF_W'(MAX_LEN);
        return CNT_W'(l);
    endfunction

endpackage

// File: rtl/core/lnp_in_if.sv
// ----------------------------------------------------------------------------
// lnp_in_if
// Command channel: load, emit-and-advance or clear items.
// ----------------------------------------------------------------------------
interface lnp_in_if;
    logic                             valid;
    logic                             ready;
    logic [lnp_pkg::KIND_W-1:0]       kind;
    logic signed [lnp_pkg::DATA_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

// File: rtl/core/lnp_out_if.sv
// ----------------------------------------------------------------------------
// lnp_out_if
// Result channel: one element of the current arrangement per item.
// ----------------------------------------------------------------------------
interface lnp_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [lnp_pkg::DATA_W-1:0] element;
    logic [lnp_pkg::POS_W-1:0]         position;
    logic                              last_of_run;
    logic                              final_arrangement;

    modport source (output valid, output element, output position,
                    output last_of_run, output final_arrangement, input ready);
    modport sink   (input valid, input element, input position,
                    input last_of_run, input final_arrangement, output ready);
endinterface

// File: rtl/core/lnp_cfg_if.sv
// ----------------------------------------------------------------------------
// lnp_cfg_if
// Configuration write channel for the length register.
// ----------------------------------------------------------------------------
interface lnp_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [lnp_pkg::LEN_W-1:0]  length_in_use;

    modport source (output valid, output length_in_use, input ready);
    modport sink   (input valid, input length_in_use, output ready);
endinterface

// File: rtl/core/lnp_store.sv
// ----------------------------------------------------------------------------
// lnp_store
// Element memory: one write port, one registered read port, write forwarding.
// ----------------------------------------------------------------------------
module lnp_store (
    input  logic                              clk,
    input  lnp_pkg::mem_wr_t                  wr,
    input  logic [lnp_pkg::IDX_W-1:0]         raddr,
    output logic signed [lnp_pkg::DATA_W-1:0] rdata
);
    import lnp_pkg::*;

    logic signed [DATA_W-1:0] store_reg [MAX_LEN];
    logic signed [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            store_reg[wr.addr] <= wr.data;
        end
        // same-cycle write to the read address returns the new data
        if (wr.we && (wr.addr == raddr))
        begin
            rdata_reg <= wr.data;
        end
        else
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/lnp_out_stage.sv
// ----------------------------------------------------------------------------
// lnp_out_stage
// Output register holding one result item until the sink takes it.
// ----------------------------------------------------------------------------
module lnp_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  lnp_pkg::res_t res,
    output logic          free,
    lnp_out_if.source     result
);
    import lnp_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t data_reg;

    assign free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign result.valid             = valid_reg;
    assign result.element           = data_reg.element;
    assign result.position          = data_reg.position;
    assign result.last_of_run       = data_reg.last_of_run;
    assign result.final_arrangement = data_reg.final_arrangement;

endmodule

// File: rtl/core/lnp_seq.sv
// ----------------------------------------------------------------------------
// lnp_seq
// Sequencer: sorted insert, pivot scan, emit, swap and suffix reversal.
// ----------------------------------------------------------------------------
module lnp_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [lnp_pkg::KIND_W-1:0]        kind,
    input  logic signed [lnp_pkg::DATA_W-1:0] value,
    input  logic [lnp_pkg::LEN_W-1:0]         len,
    output lnp_pkg::mem_wr_t                  wr,
    output logic [lnp_pkg::IDX_W-1:0]         raddr,
    input  logic signed [lnp_pkg::DATA_W-1:0] rdata,
    output logic                              res_load,
    output lnp_pkg::res_t                     res,
    input  logic                              res_free
);
    import lnp_pkg::*;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [IDX_W-1:0]         piv_reg, piv_next;
    logic [IDX_W-1:0]         lo_reg, lo_next;
    logic [IDX_W-1:0]         hi_reg, hi_next;
    logic signed [DATA_W-1:0] v_reg, v_next;
    logic signed [DATA_W-1:0] carry_reg, carry_next;
    logic signed [DATA_W-1:0] prev_reg, prev_next;
    logic signed [DATA_W-1:0] pv_reg, pv_next;
    logic signed [DATA_W-1:0] tmp_reg, tmp_next;
    logic                     found_reg, found_next;
    logic                     fin_reg, fin_next;

    logic [CNT_W-1:0] eff;
    logic [CNT_W-1:0] n_cur;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] lo_inc;
    logic [IDX_W:0]   gap;

    assign eff      = eff_len(len);
    assign n_cur    = (cnt_reg < eff) ? cnt_reg : eff;
    assign last_idx = IDX_W'(n_reg - 1'b1);
    assign lo_inc   = IDX_W'(piv_reg + 1'b1);
    assign gap      = {1'b0, hi_reg} - {1'b0, lo_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        piv_next   = piv_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        v_next     = v_reg;
        carry_next = carry_reg;
        prev_next  = prev_reg;
        pv_next    = pv_reg;
        tmp_next   = tmp_reg;
        found_next = found_reg;
        fin_next   = fin_reg;
        in_ready   = 1'b0;
        wr         = '0;
        raddr      = idx_reg;
        res_load   = 1'b0;
        res.element           = rdata;
        res.position          = POS_W'(idx_reg);
        res.last_of_run       = (idx_reg == last_idx);
        res.final_arrangement = fin_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (kind)
                        KIND_LOAD:
                        begin
                            if (cnt_reg < eff)
                            begin
                                if (cnt_reg == '0)
                                begin
                                    wr.we    = 1'b1;
                                    wr.addr  = '0;
                                    wr.data  = value;
                                    cnt_next = cnt_reg + 1'b1;
                                end
                                else
                                begin
                                    v_next     = value;
                                    idx_next   = '0;
                                    raddr      = '0;
                                    found_next = 1'b0;
                                    state_next = ST_LD_SCAN;
                                end
                            end
                        end
                        KIND_EMIT:
                        begin
                            if (n_cur != '0)
                            begin
                                n_next     = n_cur;
                                idx_next   = IDX_W'(n_cur - 1'b1);
                                raddr      = IDX_W'(n_cur - 1'b1);
                                state_next = ST_PRE;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // ripple the tail up by one from the first element above the new value
            ST_LD_SCAN:
            begin
                raddr = IDX_W'(idx_reg + 1'b1);
                if (!found_reg)
                begin
                    if (rdata > v_reg)
                    begin
                        wr.we      = 1'b1;
                        wr.addr    = idx_reg;
                        wr.data    = v_reg;
                        carry_next = rdata;
                        found_next = 1'b1;
                    end
                end
                else
                begin
                    wr.we      = 1'b1;
                    wr.addr    = idx_reg;
                    wr.data    = carry_reg;
                    carry_next = rdata;
                end
                if (idx_reg == IDX_W'(cnt_reg - 1'b1))
                begin
                    state_next = ST_LD_TAIL;
                end
                else
                begin
                    idx_next = IDX_W'(idx_reg + 1'b1);
                end
            end

            ST_LD_TAIL:
            begin
                wr.we      = 1'b1;
                wr.addr    = IDX_W'(cnt_reg);
                wr.data    = found_reg ? carry_reg : v_reg;
                cnt_next   = cnt_reg + 1'b1;
                state_next = ST_IDLE;
            end

            // right-to-left search for the rightmost strict ascent
            ST_PRE:
            begin
                raddr = IDX_W'(idx_reg - 1'b1);
                if ((idx_reg != last_idx) && (rdata < prev_reg))
                begin
                    found_next = 1'b1;
                    fin_next   = 1'b0;
                    piv_next   = idx_reg;
                    pv_next    = rdata;
                    idx_next   = '0;
                    raddr      = '0;
                    state_next = ST_EMIT;
                end
                else if (idx_reg == '0)
                begin
                    found_next = 1'b0;
                    fin_next   = 1'b1;
                    idx_next   = '0;
                    raddr      = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    prev_next = rdata;
                    idx_next  = IDX_W'(idx_reg - 1'b1);
                end
            end

            ST_EMIT:
            begin
                if (res_free)
                begin
                    res_load = 1'b1;
                    if (idx_reg == last_idx)
                    begin
                        if (found_reg)
                        begin
                            idx_next   = last_idx;
                            raddr      = last_idx;
                            state_next = ST_FIND;
                        end
                        else
                        begin
                            // no ascent: descending, reverse the whole tuple
                            lo_next = '0;
                            hi_next = last_idx;
                            raddr   = '0;
                            if (last_idx != '0)
                            begin
                                state_next = ST_REV_RD;
                            end
                            else
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                    else
                    begin
                        idx_next = IDX_W'(idx_reg + 1'b1);
                        raddr    = IDX_W'(idx_reg + 1'b1);
                    end
                end
            end

            // suffix is non-increasing: first hit from the right is the smallest larger
            ST_FIND:
            begin
                raddr = IDX_W'(idx_reg - 1'b1);
                if (rdata > pv_reg)
                begin
                    wr.we      = 1'b1;
                    wr.addr    = piv_reg;
                    wr.data    = rdata;
                    hi_next    = idx_reg;
                    state_next = ST_SWAP;
                end
                else
                begin
                    idx_next = IDX_W'(idx_reg - 1'b1);
                end
            end

            ST_SWAP:
            begin
                wr.we   = 1'b1;
                wr.addr = hi_reg;
                wr.data = pv_reg;
                lo_next = lo_inc;
                hi_next = last_idx;
                raddr   = lo_inc;
                if (lo_inc < last_idx)
                begin
                    state_next = ST_REV_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_REV_RD:
            begin
                tmp_next   = rdata;
                raddr      = hi_reg;
                state_next = ST_REV_WLO;
            end

            ST_REV_WLO:
            begin
                wr.we      = 1'b1;
                wr.addr    = lo_reg;
                wr.data    = rdata;
                state_next = ST_REV_WHI;
            end

            ST_REV_WHI:
            begin
                wr.we   = 1'b1;
                wr.addr = hi_reg;
                wr.data = tmp_reg;
                lo_next = IDX_W'(lo_reg + 1'b1);
                hi_next = IDX_W'(hi_reg - 1'b1);
                raddr   = IDX_W'(lo_reg + 1'b1);
                if (gap > (IDX_W+1)'(2))
                begin
                    state_next = ST_REV_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        idx_reg   <= idx_next;
        piv_reg   <= piv_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        v_reg     <= v_next;
        carry_reg <= carry_next;
        prev_reg  <= prev_next;
        pv_reg    <= pv_next;
        tmp_reg   <= tmp_next;
        found_reg <= found_next;
        fin_reg   <= fin_next;
    end

endmodule

// File: rtl/core/lexicographic_next_permutation.sv
// ----------------------------------------------------------------------------
// lexicographic_next_permutation
// Steps a loaded tuple of signed values through its arrangements in
// lexicographic order, one element per result item.
//
//   channel   dir   handshake      payload
//   cmd       in    valid/ready    kind, value
//   result    out   valid/ready    element, position, last_of_run,
//                                  final_arrangement
//   setup     in    valid/ready    length_in_use (always ready)
//
// one item at a time; the element memory has one read and one write port
// load: a direct write into an empty store, else a scan that ripples the
// tail up and a tail write; emit: a pivot scan, the results, then a
// partner search, a swap step and a read step and two write steps per
// swapped pair of the suffix reversal; result stalls hold the emit loop
// reset clears the count and control; the memory holds no reset value
// ----------------------------------------------------------------------------
module lexicographic_next_permutation (
    input  logic      clk,
    input  logic      rst_n,
    lnp_in_if.sink    cmd,
    lnp_out_if.source result,
    lnp_cfg_if.sink   setup
);
    import lnp_pkg::*;

    logic [LEN_W-1:0]         len_reg;
    logic [LEN_W-1:0]         len_next;
    mem_wr_t                  wr;
    logic [IDX_W-1:0]         raddr;
    logic signed [DATA_W-1:0] rdata;
    logic                     res_load;
    res_t                     res;
    logic                     res_free;

    assign setup.ready = 1'b1;

    always_comb
    begin
        len_next = len_reg;
        if (setup.valid)
        begin
            len_next = setup.length_in_use;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_W'(16);
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    lnp_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .kind     (cmd.kind),
        .value    (cmd.value),
        .len      (len_reg),
        .wr       (wr),
        .raddr    (raddr),
        .rdata    (rdata),
        .res_load (res_load),
        .res      (res),
        .res_free (res_free)
    );

    lnp_store u_store (
        .clk   (clk),
        .wr    (wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    lnp_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (res_load),
        .res    (res),
        .free   (res_free),
        .result (result)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for the lexicographic permutation block. Commands go in over
// the cmd channel in random bursts and results come back under a varying
// stall pattern. A local copy of the tuple is stepped through its
// arrangements and every result item is checked against it in order.
// ----------------------------------------------------------------------------
module tb_top;
    import lnp_pkg::*;

    localparam int unsigned RANDOM_ITEMS   = 100;
    localparam int unsigned SETTLE_CYCLES  = 64;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    logic clk;
    logic rst_n;

    lnp_in_if  cmd_if ();
    lnp_out_if res_if ();
    lnp_cfg_if cfg_if ();

    lexicographic_next_permutation dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_if),
        .result (res_if),
        .setup  (cfg_if)
    );

    // local copy of the tuple and its register
    logic signed [DATA_W-1:0] tuple [MAX_LEN];
    int unsigned              stored_count;
    logic [LEN_W-1:0]         length_reg;
    res_t                     arrangement_fifo [$];

    int unsigned effective_items;
    int unsigned mismatches;
    int unsigned burst_left;
    bit          hold_request;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned length_limit();
        int unsigned l;
        l = length_reg;
        if (l < 1) l = 1;
        if (l > MAX_LEN) l = MAX_LEN;
        return l;
    endfunction

    function automatic int rightmost_ascent(int unsigned n);
        for (int i = int'(n) - 1; i >= 1; i--)
        begin
            if (tuple[i-1] < tuple[i]) return i - 1;
        end
        return -1;
    endfunction

    function automatic void sort_span(int unsigned from, int unsigned to);
        logic signed [DATA_W-1:0] v;
        int unsigned j;
        for (int unsigned i = from + 1; i < to; i++)
        begin
            v = tuple[i];
            j = i;
            while (j > from && tuple[j-1] > v)
            begin
                tuple[j] = tuple[j-1];
                j--;
            end
            tuple[j] = v;
        end
    endfunction

    function automatic void step_arrangement(int unsigned n);
        int p;
        int unsigned best;
        logic signed [DATA_W-1:0] t;
        p = rightmost_ascent(n);
        if (p < 0)
        begin
            // descending: wrap back to sorted order
            sort_span(0, n);
            return;
        end
        best = p + 1;
        for (int unsigned i = p + 2; i < n; i++)
        begin
            if (tuple[i] > tuple[p] && tuple[i] < tuple[best]) best = i;
        end
        t = tuple[p];
        tuple[p] = tuple[best];
        tuple[best] = t;
        sort_span(p + 1, n);
    endfunction

    function automatic void apply_command(kind_t k, logic signed [DATA_W-1:0] v);
        int unsigned lim;
        int unsigned n;
        int unsigned pos;
        bit fin;
        res_t r;
        lim = length_limit();
        case (k)
            KIND_LOAD:
            begin
                if (stored_count < lim)
                begin
                    // insert before the first greater element, sorted or not
                    pos = 0;
                    while (pos < stored_count && tuple[pos] <= v) pos++;
                    for (int unsigned i = stored_count; i > pos; i--) tuple[i] = tuple[i-1];
                    tuple[pos] = v;
                    stored_count++;
                    effective_items++;
                end
            end
            KIND_EMIT:
            begin
                n = (stored_count < lim) ? stored_count : lim;
                if (n > 0)
                begin
                    fin = (rightmost_ascent(n) < 0);
                    for (int unsigned i = 0; i < n; i++)
                    begin
                        r.element           = tuple[i];
                        r.position          = POS_W'(i);
                        r.last_of_run       = (i + 1 == n);
                        r.final_arrangement = fin;
                        arrangement_fifo.push_back(r);
                    end
                    step_arrangement(n);
                    effective_items++;
                end
            end
            KIND_CLEAR:
            begin
                stored_count = 0;
                effective_items++;
            end
            default: ;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value(int unsigned flavour);
        case (flavour)
            0: return DATA_W'($urandom_range(0, 3));
            1: return DATA_W'(int'($urandom_range(0, 8)) - 4);
            default: return DATA_W'($urandom());
        endcase
    endfunction

    task automatic send_item(input kind_t k, input logic signed [DATA_W-1:0] v);
        @(negedge clk);
        if (burst_left == 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
        end
        burst_left--;
        cmd_if.valid <= 1'b1;
        cmd_if.kind  <= k;
        cmd_if.value <= v;
        do @(posedge clk); while (!cmd_if.ready);
        apply_command(k, v);
    endtask

    // drain all results, then give the block time to finish advancing
    task automatic settle();
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        while (arrangement_fifo.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_length(input logic [LEN_W-1:0] len);
        settle();
        @(negedge clk);
        cfg_if.valid         <= 1'b1;
        cfg_if.length_in_use <= len;
        do @(posedge clk); while (!cfg_if.ready);
        length_reg = len;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic test_empty_store();
        send_item(KIND_EMIT, 16'sd0);
        send_item(KIND_RSVD, 16'hFFFF);
        send_item(KIND_CLEAR, 16'sd0);
    endtask

    task automatic test_extremes();
        set_length(5'd4);
        send_item(KIND_LOAD, 16'sd32767);
        send_item(KIND_LOAD, -16'sd32768);
        send_item(KIND_LOAD, -16'sd1);
        send_item(KIND_LOAD, 16'sd0);
        // store full, ignored
        send_item(KIND_LOAD, 16'sd5);
        send_item(KIND_EMIT, 16'sd0);
        send_item(KIND_EMIT, 16'sd0);
    endtask

    task automatic test_unsorted_load();
        set_length(5'd3);
        send_item(KIND_CLEAR, 16'sd0);
        send_item(KIND_LOAD, 16'sd7);
        send_item(KIND_LOAD, 16'sd3);
        send_item(KIND_EMIT, 16'sd0);
        // store now descending, the new value lands before the first larger one
        send_item(KIND_LOAD, 16'sd5);
        send_item(KIND_EMIT, 16'sd0);
        send_item(KIND_EMIT, 16'sd0);
    endtask

    task automatic test_repeats_and_wrap();
        send_item(KIND_CLEAR, 16'sd0);
        send_item(KIND_LOAD, 16'sd5);
        send_item(KIND_LOAD, 16'sd5);
        send_item(KIND_LOAD, 16'sd2);
        repeat (4) send_item(KIND_EMIT, 16'sd0);
    endtask

    task automatic test_single_element();
        // zero length behaves as one
        set_length(5'd0);
        send_item(KIND_CLEAR, 16'sd0);
        send_item(KIND_LOAD, 16'sd9);
        send_item(KIND_LOAD, 16'sd4);
        send_item(KIND_EMIT, 16'sd0);
        send_item(KIND_EMIT, 16'sd0);
    endtask

    task automatic test_backpressure();
        // length saturates to the store depth
        set_length(5'd31);
        send_item(KIND_CLEAR, 16'sd0);
        repeat (MAX_LEN + 2) send_item(KIND_LOAD, pick_value(2));
        hold_request = 1'b1;
        repeat (3) send_item(KIND_EMIT, 16'sd0);
    endtask

    task automatic test_random();
        int unsigned target;
        int unsigned lim;
        int unsigned loads;
        int unsigned emits;
        int unsigned flavour;
        logic [LEN_W-1:0] len;
        target = effective_items + RANDOM_ITEMS;
        while (effective_items < target)
        begin
            case ($urandom_range(0, 9))
                0: len = 5'd16;
                1: len = LEN_W'($urandom_range(17, 31));
                2: len = 5'd0;
                default: len = LEN_W'($urandom_range(1, 6));
            endcase
            set_length(len);
            lim = length_limit();
            flavour = $urandom_range(0, 2);
            if ($urandom_range(0, 9) != 0) send_item(KIND_CLEAR, pick_value(2));
            loads = ($urandom_range(0, 3) == 0) ? $urandom_range(0, lim + 2) : lim;
            repeat (loads) send_item(KIND_LOAD, pick_value(flavour));
            emits = (lim > 6) ? $urandom_range(1, 3) : $urandom_range(1, 8);
            repeat (emits)
            begin
                if ($urandom_range(0, 5) == 0)
                    send_item(kind_t'($urandom_range(0, 3)), pick_value(flavour));
                send_item(KIND_EMIT, pick_value(2));
            end
        end
    endtask

    // result side: stall pattern changes per window, with one long hold-off
    initial
    begin : result_sink
        int unsigned mode;
        int unsigned window;
        int unsigned phase;
        mode = 0;
        window = 0;
        phase = 0;
        res_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (window == 0)
            begin
                mode = $urandom_range(0, 3);
                window = $urandom_range(8, 64);
            end
            window--;
            phase++;
            case (mode)
                0: res_if.ready <= 1'b1;
                1: res_if.ready <= ($urandom_range(0, 3) != 0);
                2: res_if.ready <= 1'($urandom_range(0, 1));
                default: res_if.ready <= ((phase % 5) < 2);
            endcase
        end
    end

    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (arrangement_fifo.size() == 0)
            begin
                $error("result item with nothing pending: element %0d position %0d",
                       res_if.element, res_if.position);
                mismatches++;
            end
            else
            begin
                want = arrangement_fifo.pop_front();
                if (res_if.element !== want.element)
                begin
                    $error("element expected %0d actual %0d", want.element, res_if.element);
                    mismatches++;
                end
                if (res_if.position !== want.position)
                begin
                    $error("position expected %0d actual %0d", want.position, res_if.position);
                    mismatches++;
                end
                if (res_if.last_of_run !== want.last_of_run)
                begin
                    $error("last_of_run expected %0b actual %0b",
                           want.last_of_run, res_if.last_of_run);
                    mismatches++;
                end
                if (res_if.final_arrangement !== want.final_arrangement)
                begin
                    $error("final_arrangement expected %0b actual %0b",
                           want.final_arrangement, res_if.final_arrangement);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("lexicographic_next_permutation regression: fail");
        $finish;
    end

    initial
    begin
        rst_n                = 1'b0;
        cmd_if.valid         = 1'b0;
        cmd_if.kind          = KIND_LOAD;
        cmd_if.value         = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.length_in_use = 5'd16;
        length_reg           = 5'd16;
        stored_count         = 0;
        effective_items      = 0;
        mismatches           = 0;
        burst_left           = 0;
        hold_request         = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_store();
        test_extremes();
        test_unsorted_load();
        test_repeats_and_wrap();
        test_single_element();
        test_backpressure();
        test_random();

        settle();
        if (mismatches == 0)
            $display("lexicographic_next_permutation regression: pass");
        else
            $display("lexicographic_next_permutation regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/lnp_pkg.sv
rtl/core/lnp_in_if.sv
rtl/core/lnp_out_if.sv
rtl/core/lnp_cfg_if.sv
rtl/core/lnp_store.sv
rtl/core/lnp_out_stage.sv
rtl/core/lnp_seq.sv
rtl/core/lexicographic_next_permutation.sv
tb/tb_top.sv
